// File: rtl/length_prefixed_frame_deframer_macros.svh
// Assertion macros for the length-prefixed frame deframer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// General concurrent property on the block clock.
`define LPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define LPFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned BUF_LIMIT_W   = 20;
  localparam int unsigned MAX_PAYLOAD_W = 16;
  localparam int unsigned PARTIAL_W     = 17;

  // Register indexes, taken from paddr[2].
  localparam logic REG_BUF_LIMIT   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  // Position within the frame header; the last code means payload phase.
  localparam logic [2:0] HC_ID_FIRST = 3'd0;
  localparam logic [2:0] HC_LEN_HI   = 3'd4;
  localparam logic [2:0] HC_LEN_LO   = 3'd5;
  localparam logic [2:0] HC_COMMAND  = 3'd6;
  localparam logic [2:0] HC_PAYLOAD  = 3'd7;

  localparam logic CAUSE_BUFFER = 1'b0;
  localparam logic CAUSE_LENGTH = 1'b1;

  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        chunk_first;
    logic [15:0] chunk_size;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] flow_id;
    logic [7:0]  command;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic        error_cause;
  } out_item_t;

  typedef struct packed {
    logic [BUF_LIMIT_W-1:0]   buf_limit;
    logic [MAX_PAYLOAD_W-1:0] max_payload;
  } cfg_t;

endpackage

// File: rtl/length_prefixed_frame_deframer.sv
// A byte passes the input register, then the result register, before its result is offered.
// Throughput: one byte per cycle while the output is not stalled; the input register holds one
// byte while the result waits. Bytes that are dropped or sit inside a header give no result.
// Reset (rst_ni low, asynchronous) clears the parser state and both stage valids,
// sets buf_limit to 0 and max_payload to 65535.
// Top level of the deframer; depends on lpfd_pkg, lpfd_cfg and lpfd_core.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lpfd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lpfd_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lpfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  lpfd_pkg::cfg_t      cfg;
  lpfd_pkg::in_item_t  in_q;
  logic                in_valid_q;
  lpfd_pkg::out_item_t out_q;
  logic                out_valid_q;
  lpfd_pkg::out_item_t res;
  logic                res_valid;
  logic                advance;
  logic                accept;

  // The held byte moves on whenever the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  lpfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/lpfd_cfg.sv
// APB-style configuration registers for the frame deframer.
// Depends on lpfd_pkg for widths, register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module lpfd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lpfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output lpfd_pkg::cfg_t                  cfg_o
);

  logic [lpfd_pkg::BUF_LIMIT_W-1:0]   buf_limit_q;
  logic [lpfd_pkg::MAX_PAYLOAD_W-1:0] max_payload_q;
  logic                               wr_en;
  logic                               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_limit_q   <= '0;
      max_payload_q <= lpfd_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        lpfd_pkg::REG_BUF_LIMIT:   buf_limit_q   <= pwdata[lpfd_pkg::BUF_LIMIT_W-1:0];
        lpfd_pkg::REG_MAX_PAYLOAD: max_payload_q <= pwdata[lpfd_pkg::MAX_PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lpfd_pkg::REG_BUF_LIMIT:
        prdata = {{(lpfd_pkg::APB_DATA_W-lpfd_pkg::BUF_LIMIT_W){1'b0}}, buf_limit_q};
      lpfd_pkg::REG_MAX_PAYLOAD:
        prdata = {{(lpfd_pkg::APB_DATA_W-lpfd_pkg::MAX_PAYLOAD_W){1'b0}}, max_payload_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.buf_limit   = buf_limit_q;
  assign cfg_o.max_payload = max_payload_q;

endmodule

// File: rtl/lpfd_core.sv
// Frame parser state and per-byte decision logic for the frame deframer.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_macros.svh.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lpfd_pkg::in_item_t  item_i,
  input  lpfd_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output lpfd_pkg::out_item_t res_o
);

  logic [2:0]                     hc_q, hc_d;
  logic [31:0]                    id_q, id_d;
  logic [15:0]                    len_q, len_d;
  logic [7:0]                     cmd_q, cmd_d;
  logic [15:0]                    pl_q, pl_d;
  logic [lpfd_pkg::PARTIAL_W-1:0] partial_q, partial_d;
  logic                           discard_q, discard_d;

  logic                           discard_eff;
  logic [lpfd_pkg::BUF_LIMIT_W-1:0] limit_sum;
  logic                           limit_err;
  logic [15:0]                    pl_dec;

  assign discard_eff = item_i.chunk_first ? 1'b0 : discard_q;
  // The sum is at most 18 bits wide, so it never wraps in 20 bits.
  assign limit_sum = {3'b000, partial_q} + {4'b0000, item_i.chunk_size};
  assign limit_err = item_i.chunk_first && (cfg_i.buf_limit != '0) &&
                     (limit_sum > cfg_i.buf_limit);
  assign pl_dec = (pl_q != 16'd0) ? pl_q - 16'd1 : 16'd0;

  always_comb begin
    hc_d        = hc_q;
    id_d        = id_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    pl_d        = pl_q;
    partial_d   = partial_q;
    discard_d   = discard_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      discard_d = discard_eff;
      if (limit_err) begin
        res_valid_o       = 1'b1;
        res_o.kind        = lpfd_pkg::KIND_ERROR;
        res_o.error_cause = lpfd_pkg::CAUSE_BUFFER;
        hc_d      = lpfd_pkg::HC_ID_FIRST;
        pl_d      = '0;
        partial_d = '0;
        discard_d = 1'b1;
      end else if (!discard_eff) begin
        partial_d = partial_q + 1'b1;
        if (hc_q != lpfd_pkg::HC_PAYLOAD) begin
          case (hc_q)
            lpfd_pkg::HC_ID_FIRST: id_d  = {24'd0, item_i.data_byte};
            lpfd_pkg::HC_LEN_HI:   len_d = {item_i.data_byte, 8'd0};
            lpfd_pkg::HC_LEN_LO:   len_d = len_q | {8'd0, item_i.data_byte};
            lpfd_pkg::HC_COMMAND:  cmd_d = item_i.data_byte;
            default:               id_d  = {id_q[23:0], item_i.data_byte};
          endcase

          if (hc_q != lpfd_pkg::HC_COMMAND) begin
            hc_d = hc_q + 3'd1;
          end else begin
            // Header complete: the length is already in len_q.
            res_valid_o        = 1'b1;
            res_o.flow_id      = id_q;
            res_o.command      = item_i.data_byte;
            res_o.frame_length = len_q;
            if (len_q > cfg_i.max_payload) begin
              res_o.kind        = lpfd_pkg::KIND_ERROR;
              res_o.error_cause = lpfd_pkg::CAUSE_LENGTH;
              hc_d      = lpfd_pkg::HC_ID_FIRST;
              pl_d      = '0;
              partial_d = '0;
              discard_d = 1'b1;
            end else if (len_q == 16'd0) begin
              res_o.kind       = lpfd_pkg::KIND_HEADER;
              res_o.frame_last = 1'b1;
              hc_d      = lpfd_pkg::HC_ID_FIRST;
              pl_d      = '0;
              partial_d = '0;
            end else begin
              res_o.kind = lpfd_pkg::KIND_HEADER;
              hc_d       = lpfd_pkg::HC_PAYLOAD;
              pl_d       = len_q;
            end
          end
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = lpfd_pkg::KIND_PAYLOAD;
          res_o.flow_id      = id_q;
          res_o.command      = cmd_q;
          res_o.frame_length = len_q;
          res_o.payload_byte = item_i.data_byte;
          res_o.frame_last   = (pl_dec == 16'd0);
          pl_d               = pl_dec;
          if (pl_dec == 16'd0) begin
            hc_d      = lpfd_pkg::HC_ID_FIRST;
            partial_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q      <= lpfd_pkg::HC_ID_FIRST;
      id_q      <= '0;
      len_q     <= '0;
      cmd_q     <= '0;
      pl_q      <= '0;
      partial_q <= '0;
      discard_q <= 1'b0;
    end else begin
      hc_q      <= hc_d;
      id_q      <= id_d;
      len_q     <= len_d;
      cmd_q     <= cmd_d;
      pl_q      <= pl_d;
      partial_q <= partial_d;
      discard_q <= discard_d;
    end
  end

  `LPFD_ASSERT_IMPLIES(a_discard_clean, discard_q,
    (hc_q == lpfd_pkg::HC_ID_FIRST) && (partial_q == '0) && (pl_q == '0),
    "partial frame not cleared while dropping a chunk")
  `LPFD_ASSERT_IMPLIES(a_header_count_match, hc_q != lpfd_pkg::HC_PAYLOAD,
    (pl_q == '0) && (partial_q == {14'd0, hc_q}),
    "byte count disagrees with header position")
  `LPFD_ASSERT_IMPLIES(a_payload_pending, hc_q == lpfd_pkg::HC_PAYLOAD, pl_q != '0,
    "payload phase with no bytes left")
  `LPFD_ASSERT(a_error_drops, step_i && res_valid_o && (res_o.kind == lpfd_pkg::KIND_ERROR)
    |=> discard_q, "error did not start dropping the chunk")

endmodule
